// ===== sv/cma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered moving average package
// Shared widths and the window length rule for the averaging block.
// ----------------------------------------------------------------------------
package cma_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int LEN_BITS    = 6;
   localparam int INDEX_BITS  = 16;
   localparam int PTR_BITS    = $clog2(MAX_WINDOW);
   localparam int FILL_BITS   = $clog2(MAX_WINDOW + 1);
   // A window of up to 63 full-scale samples needs six extra bits of headroom.
   localparam int SUM_BITS    = SAMPLE_BITS + LEN_BITS;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

   localparam logic [LEN_BITS-1:0] WINDOW_LEN_RESET = LEN_BITS'(11);
   // Largest odd length that still fits in the store.
   localparam int LEN_CAP = ((MAX_WINDOW - 1) % 2 == 0) ? MAX_WINDOW - 2 : MAX_WINDOW - 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;

   // Zero is taken as one, even lengths drop to the next lower odd value.
   function automatic logic [LEN_BITS-1:0] effective_len(input logic [LEN_BITS-1:0] len);
      logic [LEN_BITS-1:0] n;
      n = len;
      if (n == '0) begin
         n = LEN_BITS'(1);
      end
      if (!n[0]) begin
         n = n - LEN_BITS'(1);
      end
      if (32'(n) > LEN_CAP) begin
         n = LEN_BITS'(LEN_CAP);
      end
      return n;
   endfunction

endpackage

// ===== sv/cma_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window sum divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module cma_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  cma_pkg::sum_type                    dividend,
   input  logic [cma_pkg::LEN_BITS-1:0]        divisor,
   output logic                                done,
   output cma_pkg::sample_type                 quotient
);
   import cma_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic [LEN_BITS-1:0]     div_ff, div_in;
   logic [LEN_BITS-1:0]     rem_ff, rem_in;
   logic [SUM_BITS-1:0]     quo_ff, quo_in;
   sample_type              quot_ff, quot_in;

   logic [LEN_BITS:0]   trial;
   logic                fits;
   logic [SUM_BITS-1:0] mag;
   logic [SUM_BITS-1:0] signed_quo;

   always_comb begin
      trial = {rem_ff, quo_ff[SUM_BITS-1]};
      fits  = trial >= {1'b0, div_ff};
      mag   = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
      signed_quo = neg_ff ? -{quo_ff[SUM_BITS-2:0], fits} : {quo_ff[SUM_BITS-2:0], fits};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(SUM_BITS);
         neg_in  = dividend[SUM_BITS-1];
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = mag;
      end else if (busy_ff) begin
         rem_in = fits ? LEN_BITS'(trial - {1'b0, div_ff}) : trial[LEN_BITS-1:0];
         quo_in = {quo_ff[SUM_BITS-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = signed_quo[SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== sv/centered_moving_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered moving average
// Boxcar mean over the last window_len samples (forced odd), tagged with the center index.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the req_ channel (req_tdata = sample, req_tlast marks the
//   final sample of a signal). Each sample is written to a 64-entry ring store.
//   Once the current signal has supplied at least N samples (N = window_len,
//   forced odd), the item yields one result on the rsp_ channel: the window
//   mean truncated toward zero and the signal position of the center sample.
//   Items without a full window yield nothing and leave the block idle.
//   An item with a result forms the sum from N reads of the store through
//   its one read port, then runs a bit-serial divide by N.
//   The next item is accepted once the result sits in the output register,
//   so a stalled receiver delays input only when a second result is ready.
//   After req_tlast the sample count, fill count and pointer restart at zero.
//   Reset clears all control state and sets window_len to 11; the store
//   needs no clearing since entries are read only after being written.
//   csr_wr_en writes window_len; write it only while the block is idle.
// ----------------------------------------------------------------------------
module centered_moving_average (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration
   input  logic                               csr_wr_en,
   input  logic [cma_pkg::LEN_BITS-1:0]       csr_wr_data,
   // Input items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cma_pkg::SAMPLE_BITS-1:0]    req_tdata,   // [15:0] sample
   input  logic                               req_tlast,   // last_sample
   // Result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cma_pkg::SAMPLE_BITS+cma_pkg::INDEX_BITS-1:0] rsp_tdata
                                                           // [15:0] average,
                                                           // [31:16] center_index
);
   import cma_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   // Ring store with a registered read port.
   sample_type store_mem [MAX_WINDOW];
   sample_type rd_data_ff;

   logic [1:0]            state_ff, state_in;
   logic [LEN_BITS-1:0]   window_len_ff;
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic [INDEX_BITS-1:0] seen_ff, seen_in;
   logic [PTR_BITS-1:0]   rd_addr_ff, rd_addr_in;
   logic [LEN_BITS-1:0]   rd_cnt_ff, rd_cnt_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [LEN_BITS-1:0]   n_ff, n_in;
   logic [INDEX_BITS-1:0] center_ff, center_in;
   sum_type               acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS+INDEX_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [LEN_BITS-1:0]   n_now;
   logic [FILL_BITS-1:0]  fill_next;
   logic                  div_start;
   logic                  div_done;
   sample_type            div_quot;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign n_now      = effective_len(window_len_ff);
   assign fill_next  = (32'(fill_ff) < MAX_WINDOW) ? fill_ff + FILL_BITS'(1) : fill_ff;

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      fill_in      = fill_ff;
      seen_in      = seen_ff;
      rd_addr_in   = rd_addr_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_valid_in  = 1'b0;
      n_in         = n_ff;
      center_in    = center_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;

      if (rd_valid_ff) begin
         acc_in = acc_ff + SUM_BITS'(rd_data_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wr_ptr_in  = wr_ptr_ff + PTR_BITS'(1);
               fill_in    = fill_next;
               seen_in    = seen_ff + INDEX_BITS'(1);
               n_in       = n_now;
               // Center is the newest position minus half the window.
               center_in  = seen_ff - INDEX_BITS'(n_now >> 1);
               rd_addr_in = wr_ptr_ff;
               rd_cnt_in  = n_now;
               acc_in     = '0;
               if (32'(fill_next) >= 32'(n_now)) begin
                  state_in = ST_SUM;
               end
               if (req_tlast) begin
                  wr_ptr_in = '0;
                  fill_in   = '0;
                  seen_in   = '0;
               end
            end
         end
         ST_SUM: begin
            if (rd_cnt_ff != '0) begin
               rd_valid_in = 1'b1;
               rd_addr_in  = rd_addr_ff - PTR_BITS'(1);
               rd_cnt_in   = rd_cnt_ff - LEN_BITS'(1);
            end else if (!rd_valid_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {center_ff, div_quot};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_mem[wr_ptr_ff] <= req_tdata;
      end
      rd_data_ff <= store_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= WINDOW_LEN_RESET;
         wr_ptr_ff     <= '0;
         fill_ff       <= '0;
         seen_ff       <= '0;
         rd_cnt_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         seen_ff      <= seen_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            window_len_ff <= csr_wr_data;
         end
      end
      rd_addr_ff  <= rd_addr_in;
      n_ff        <= n_in;
      center_ff   <= center_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   cma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
